// File: rtl/smallest_missing_positive_assert.svh
// Assertion macros shared by the smallest missing positive search block.
`ifndef SMALLEST_MISSING_POSITIVE_ASSERT_SVH
`define SMALLEST_MISSING_POSITIVE_ASSERT_SVH

// Checks an implication on the rising clock edge, idle while reset is high.
`define SMP_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Checks an implication in the following cycle, idle while reset is high.
`define SMP_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: rtl/smp_pkg.sv
// Package with sizes and controller-datapath interface types of the search block.
package smp_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int ANS_W     = $clog2(MAX_ITEMS + 2);
  localparam int VAL_W     = 32;
  localparam int MISS_W    = 11;

  typedef struct packed {
    logic load_en;
    logic scan_start;
    logic scan_en;
    logic out_load;
    logic clr_en;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic clr_done;
    logic out_free;
  } dp_sts_t;

endpackage

// File: rtl/smp_ctrl.sv
// Controller state machine that sequences loading, scanning, result hand-off and clearing.
module smp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             is_last,
  input  smp_pkg::dp_sts_t sts,
  output smp_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_FOUND,
    ST_CLEAR
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_LOAD: begin
        in_stall    = 1'b0;
        cmd.load_en = in_valid;
        if (in_valid && is_last) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_FOUND;
        end
      end
      ST_FOUND: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_done) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: rtl/smp_dp.sv
// Datapath with the presence bitmap memory, counters, scan pipeline and output register.
`include "smallest_missing_positive_assert.svh"

module smp_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [smp_pkg::VAL_W-1:0]     value,
  input  smp_pkg::dp_cmd_t                     cmd,
  output smp_pkg::dp_sts_t                     sts,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [smp_pkg::MISS_W-1:0]    missing_value,
  output logic                                 overflow
);

  logic                        mem [smp_pkg::MAX_ITEMS];
  logic                        rd_data;
  logic [smp_pkg::VAL_W-1:0]   value_u;
  logic                        in_range;
  logic [smp_pkg::IDX_W-1:0]   wr_idx;
  logic                        wr_en;
  logic [smp_pkg::IDX_W-1:0]   wr_addr;
  logic                        wr_bit;

  logic [smp_pkg::CNT_W-1:0]   count;
  logic                        ovf;
  logic [smp_pkg::CNT_W-1:0]   scan_idx;
  logic                        rd_pend;
  logic [smp_pkg::IDX_W-1:0]   rd_idx;
  logic                        last_idx;
  logic                        scan_hit;
  logic [smp_pkg::ANS_W-1:0]   ans;
  logic [smp_pkg::ANS_W-1:0]   ans_next;
  logic [smp_pkg::IDX_W-1:0]   clr_idx;
  logic                        clr_last;

  assign value_u  = $unsigned(value);
  assign in_range = (value_u >= smp_pkg::VAL_W'(1)) &&
                    (value_u <= smp_pkg::VAL_W'(smp_pkg::MAX_ITEMS));
  assign wr_idx   = smp_pkg::IDX_W'(value_u - smp_pkg::VAL_W'(1));
  assign wr_en    = cmd.clr_en || (cmd.load_en && in_range);
  assign wr_addr  = cmd.clr_en ? clr_idx : wr_idx;
  assign wr_bit   = !cmd.clr_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
    rd_data <= mem[scan_idx[smp_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.load_en) begin
      if (count < smp_pkg::CNT_W'(smp_pkg::MAX_ITEMS)) begin
        count <= count + smp_pkg::CNT_W'(1);
      end else begin
        ovf <= 1'b1;
      end
    end else if (cmd.out_load) begin
      count <= '0;
      ovf   <= 1'b0;
    end
  end

  assign last_idx = (smp_pkg::CNT_W'(rd_idx) + smp_pkg::CNT_W'(1)) == count;
  assign scan_hit = cmd.scan_en && rd_pend && (!rd_data || last_idx);
  assign ans_next = !rd_data ? (smp_pkg::ANS_W'(rd_idx) + smp_pkg::ANS_W'(1))
                             : (smp_pkg::ANS_W'(count) + smp_pkg::ANS_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_pend  <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_idx <= '0;
      rd_pend  <= 1'b0;
    end else if (cmd.scan_en) begin
      if (scan_idx < count) begin
        rd_pend  <= 1'b1;
        scan_idx <= scan_idx + smp_pkg::CNT_W'(1);
      end else begin
        rd_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      rd_idx <= scan_idx[smp_pkg::IDX_W-1:0];
    end
    if (scan_hit) begin
      ans <= ans_next;
    end
  end

  assign clr_last = clr_idx == smp_pkg::IDX_W'(smp_pkg::MAX_ITEMS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_en) begin
      clr_idx <= clr_last ? '0 : clr_idx + smp_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      missing_value <= smp_pkg::MISS_W'(ans);
      overflow      <= ovf;
    end
  end

  assign sts.scan_done = scan_hit;
  assign sts.clr_done  = cmd.clr_en && clr_last;
  assign sts.out_free  = !out_valid || !out_stall;

  `SMP_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !out_valid || !out_stall,
    "Result word overwritten while still held")
  `SMP_ASSERT_IMPL(a_clear_no_load, cmd.clr_en, !cmd.load_en,
    "Input word accepted during bitmap clearing")
  `SMP_ASSERT_IMPL(a_answer_range, scan_hit,
    (ans_next != '0) && (ans_next <= smp_pkg::ANS_W'(count) + smp_pkg::ANS_W'(1)),
    "Scan answer outside one to count plus one")
  `SMP_ASSERT_NEXT(a_result_shown, cmd.out_load, out_valid && (missing_value != '0),
    "Result word not presented after load")

endmodule

// File: rtl/smallest_missing_positive.sv
// Loading takes one word per cycle; the bitmap scan reads one entry per cycle from its memory.
// After each result is registered, a clearing sweep of the bitmap runs with the input stalled.
// Reset is synchronous and active high; it starts the same clearing sweep.
// Top level of the smallest missing positive search block.
module smallest_missing_positive (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [smp_pkg::VAL_W-1:0]  value,
  input  logic                              is_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic        [smp_pkg::MISS_W-1:0] missing_value,
  output logic                              overflow
);

  smp_pkg::dp_cmd_t cmd;
  smp_pkg::dp_sts_t sts;

  smp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .is_last  (is_last),
    .sts      (sts),
    .cmd      (cmd)
  );

  smp_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .value         (value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .missing_value (missing_value),
    .overflow      (overflow)
  );

endmodule
